### rtl/idd_pkg.sv
`timescale 1ns / 1ps

package idd_pkg;

	localparam logic [7:0] MARKER_RESET = 8'h1C;
	localparam int MIN_LEFT = 6;
	localparam int SOS_MAX = 4;
	localparam int EXT_FLAG_BIT = 7;
	localparam logic [14:0] SOS_MASK = 15'h7FFF;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SOS = 2'd1;
	localparam logic [1:0] ST_LEN_PAST = 2'd2;
	localparam logic [1:0] ST_PAY_PAST = 2'd3;

	// classified input item, front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic [31:0] rem;
		logic n_lt6;
		logic rem_lt6;
		logic is_marker;
	} mid_item_t;

	// one result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] record_id;
		logic [7:0] dataset_id;
		logic [31:0] payload_length;
		logic [7:0] payload_byte;
		logic payload_last;
		logic done_res;
		logic [1:0] status;
	} res_item_t;

endpackage

### rtl/idd_fifo.sv
`timescale 1ns / 1ps

module idd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

### rtl/idd_front.sv
`timescale 1ns / 1ps

module idd_front (
	input logic clk,
	input logic arst_n,
	input logic marker_we,
	input logic [7:0] marker_byte,
	input logic [7:0] data_byte,
	input logic [31:0] bytes_left,
	output idd_pkg::mid_item_t item
);

	import idd_pkg::*;

	logic [7:0] marker_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (marker_we) begin
			marker_q <= marker_byte;
		end
	end

	// a zero count is taken as one
	always_comb begin
		item.data_byte = data_byte;
		item.rem = (bytes_left == '0) ? '0 : bytes_left - 32'd1;
		item.n_lt6 = (bytes_left < 32'(MIN_LEFT));
		item.rem_lt6 = (bytes_left < 32'(MIN_LEFT + 1));
		item.is_marker = (data_byte == marker_q);
	end

endmodule

### rtl/idd_back.sv
`timescale 1ns / 1ps

module idd_back #(
	parameter int LENGTH_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input idd_pkg::mid_item_t item,
	input logic item_empty,
	output logic item_pop,
	output idd_pkg::res_item_t res,
	output logic res_push,
	input logic res_full
);

	import idd_pkg::*;

	localparam logic [2:0] PH_SEARCH = 3'd0;
	localparam logic [2:0] PH_RECORD = 3'd1;
	localparam logic [2:0] PH_DATASET = 3'd2;
	localparam logic [2:0] PH_LEN_HI = 3'd3;
	localparam logic [2:0] PH_LEN_LO = 3'd4;
	localparam logic [2:0] PH_EXT = 3'd5;
	localparam logic [2:0] PH_PAYLOAD = 3'd6;
	localparam logic [2:0] PH_DONE = 3'd7;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	logic [2:0] phase_q, phase_d;
	logic [7:0] rec_q, rec_d;
	logic [7:0] ds_q, ds_d;
	logic [7:0] first_q, first_d;
	logic [2:0] ext_q, ext_d;
	logic [LENGTH_BITS-1:0] accum_q, accum_d;
	logic [LENGTH_BITS-1:0] pay_rem_q, pay_rem_d;

	logic take;
	logic fin_go;
	logic [LENGTH_BITS-1:0] fin_len;
	logic [14:0] sos;
	logic accum_sat;
	logic [LENGTH_BITS-1:0] accum_shift;
	logic [2:0] ext_dec;

	assign take = !item_empty && !res_full;
	assign item_pop = take;
	assign sos = {first_q[6:0], item.data_byte} & SOS_MASK;
	assign accum_sat = (accum_q[LENGTH_BITS-1 -: 8] != 8'd0);
	assign accum_shift = accum_sat ? LEN_MAX : {accum_q[LENGTH_BITS-9:0], item.data_byte};
	assign ext_dec = ext_q - 3'd1;

	always_comb begin
		phase_d = phase_q;
		rec_d = rec_q;
		ds_d = ds_q;
		first_d = first_q;
		ext_d = ext_q;
		accum_d = accum_q;
		pay_rem_d = pay_rem_q;
		fin_go = 1'b0;
		fin_len = '0;
		res_push = 1'b0;
		res = '0;
		res.record_id = rec_q;
		res.dataset_id = ds_q;
		if (take) begin
			case (phase_q)
				PH_SEARCH: begin
					if (item.n_lt6) begin
						phase_d = PH_DONE;
						res_push = 1'b1;
						res.kind = KIND_STATUS;
						res.done_res = 1'b1;
					end else if (item.is_marker) begin
						phase_d = PH_RECORD;
					end else if (item.rem_lt6) begin
						phase_d = PH_DONE;
						res_push = 1'b1;
						res.kind = KIND_STATUS;
						res.done_res = 1'b1;
					end
				end
				PH_RECORD: begin
					rec_d = item.data_byte;
					phase_d = PH_DATASET;
				end
				PH_DATASET: begin
					ds_d = item.data_byte;
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					first_d = item.data_byte;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (first_q[EXT_FLAG_BIT]) begin
						accum_d = '0;
						if (sos > 15'(SOS_MAX)) begin
							phase_d = PH_DONE;
							res_push = 1'b1;
							res.kind = KIND_STATUS;
							res.done_res = 1'b1;
							res.status = ST_SOS;
						end else if (32'(sos) > item.rem) begin
							phase_d = PH_DONE;
							res_push = 1'b1;
							res.kind = KIND_STATUS;
							res.done_res = 1'b1;
							res.status = ST_LEN_PAST;
						end else if (sos == 15'd0) begin
							fin_go = 1'b1;
							fin_len = '0;
						end else begin
							ext_d = sos[2:0];
							phase_d = PH_EXT;
						end
					end else begin
						fin_go = 1'b1;
						fin_len = LENGTH_BITS'({first_q, item.data_byte});
						accum_d = fin_len;
					end
				end
				PH_EXT: begin
					accum_d = accum_shift;
					ext_d = ext_dec;
					if (ext_dec == 3'd0) begin
						fin_go = 1'b1;
						fin_len = accum_shift;
					end
				end
				PH_PAYLOAD: begin
					res_push = 1'b1;
					res.kind = KIND_PAYLOAD;
					res.payload_length = 32'(accum_q);
					res.payload_byte = item.data_byte;
					if (pay_rem_q <= LENGTH_BITS'(1)) begin
						res.payload_last = 1'b1;
						pay_rem_d = '0;
						if (item.rem_lt6) begin
							phase_d = PH_DONE;
							res.done_res = 1'b1;
						end else begin
							phase_d = PH_SEARCH;
						end
					end else begin
						pay_rem_d = pay_rem_q - LENGTH_BITS'(1);
					end
				end
				default: begin
				end
			endcase
			// complete length, checked against the bytes after this one
			if (fin_go) begin
				res_push = 1'b1;
				res.payload_length = 32'(fin_len);
				if (32'(fin_len) > item.rem) begin
					phase_d = PH_DONE;
					res.kind = KIND_STATUS;
					res.done_res = 1'b1;
					res.status = ST_PAY_PAST;
				end else if (fin_len != '0) begin
					pay_rem_d = fin_len;
					phase_d = PH_PAYLOAD;
					res.kind = KIND_HEADER;
				end else if (item.rem_lt6) begin
					phase_d = PH_DONE;
					res.kind = KIND_HEADER;
					res.done_res = 1'b1;
				end else begin
					phase_d = PH_SEARCH;
					res.kind = KIND_HEADER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			rec_q <= '0;
			ds_q <= '0;
			first_q <= '0;
			ext_q <= '0;
			accum_q <= '0;
			pay_rem_q <= '0;
		end else begin
			phase_q <= phase_d;
			rec_q <= rec_d;
			ds_q <= ds_d;
			first_q <= first_d;
			ext_q <= ext_d;
			accum_q <= accum_d;
			pay_rem_q <= pay_rem_d;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");
	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.done_res) |=> (phase_q == PH_DONE))
		else $error("done result without done phase");
	a_quiet_done: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> !res_push)
		else $error("result after parsing finished");
	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXT) |-> (ext_q != 3'd0))
		else $error("extended length phase with no bytes to go");
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (pay_rem_q != '0))
		else $error("payload phase with nothing left");
`endif

endmodule

### rtl/iptc_dataset_deframer.sv
`timescale 1ns / 1ps

// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// input    | push / full         | data_byte, bytes_left
// result   | empty / pop         | kind, record_id, dataset_id, payload_length,
//          |                     | payload_byte, payload_last, done_res, status
// config   | marker_we           | marker_byte
//
// one item per cycle is accepted while full is low, and one result per cycle is
// delivered while results wait and pop is high; a result shows on the ports once
// its item has left the input queue and its result sits in the result queue
// reset clears the marker to 0x1c and puts the parser in the marker search
// the parser takes an item only while the result queue has room, so a stalled
// result side fills the result queue, then the input queue, then raises full

module iptc_dataset_deframer #(
	parameter int LENGTH_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic marker_we,
	input logic [7:0] marker_byte,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	input logic [31:0] bytes_left,
	output logic empty,
	input logic pop,
	output logic [1:0] kind,
	output logic [7:0] record_id,
	output logic [7:0] dataset_id,
	output logic [31:0] payload_length,
	output logic [7:0] payload_byte,
	output logic payload_last,
	output logic done_res,
	output logic [1:0] status
);

	import idd_pkg::*;

	// classified item before and after the input queue
	mid_item_t front_item;
	mid_item_t back_item;
	logic mid_empty;
	logic mid_pop;

	// result between parser and result queue
	res_item_t back_res;
	res_item_t out_res;
	logic res_push;
	logic res_full;

	// front: marker register and per-byte classification
	idd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.marker_we(marker_we),
		.marker_byte(marker_byte),
		.data_byte(data_byte),
		.bytes_left(bytes_left),
		.item(front_item)
	);

	// short queue that lets the front accept while the parser waits
	idd_fifo #(
		.WIDTH($bits(mid_item_t)),
		.DEPTH(4)
	) u_mid_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(front_item),
		.full(full),
		.pop(mid_pop),
		.rdata(back_item),
		.empty(mid_empty)
	);

	// back: header and payload state machine
	idd_back #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item(back_item),
		.item_empty(mid_empty),
		.item_pop(mid_pop),
		.res(back_res),
		.res_push(res_push),
		.res_full(res_full)
	);

	// result queue, oldest result shown on the ports
	idd_fifo #(
		.WIDTH($bits(res_item_t)),
		.DEPTH(4)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(back_res),
		.full(res_full),
		.pop(pop),
		.rdata(out_res),
		.empty(empty)
	);

	assign kind = out_res.kind;
	assign record_id = out_res.record_id;
	assign dataset_id = out_res.dataset_id;
	assign payload_length = out_res.payload_length;
	assign payload_byte = out_res.payload_byte;
	assign payload_last = out_res.payload_last;
	assign done_res = out_res.done_res;
	assign status = out_res.status;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import idd_pkg::*;

	localparam int LENGTH_BITS = 32;
	localparam logic [39:0] LEN_ALL_ONES = (40'd1 << LENGTH_BITS) - 40'd1;
	// quiet cycles after the last expected result before a marker write
	localparam int SETTLE_CYCLES = 8;
	// long receiver hold-offs, keyed to the count of results taken
	localparam int HOLD_AT_A = 60;
	localparam int HOLD_AT_B = 250;
	localparam int HOLD_CYCLES = 300;
	localparam int TARGET_ITEMS = 440;

	// parser phases of the prediction
	typedef enum logic [2:0] {
		HUNT, GET_RECORD, GET_DATASET, GET_LEN_HI, GET_LEN_LO, GET_EXT, IN_PAYLOAD, FINISHED
	} parse_phase_t;

	// how the buffer ends; only one ending per run since parsing never restarts
	typedef enum int {
		END_ON_PAYLOAD, END_ON_EMPTY, END_ON_SKIP, END_SHORT, END_SOS_OVER, END_LEN_PAST,
		END_PAY_PAST
	} ending_t;

	// one entry of the feed: a byte item or a marker write
	typedef struct {
		bit is_marker_write;
		logic [7:0] value;
		logic [31:0] left;
	} feed_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic marker_we = 1'b0;
	logic [7:0] marker_byte = MARKER_RESET;
	logic push = 1'b0;
	logic full;
	logic [7:0] data_byte = 8'd0;
	logic [31:0] bytes_left = 32'd0;
	logic empty;
	logic pop = 1'b0;
	logic [1:0] kind;
	logic [7:0] record_id;
	logic [7:0] dataset_id;
	logic [31:0] payload_length;
	logic [7:0] payload_byte;
	logic payload_last;
	logic done_res;
	logic [1:0] status;

	iptc_dataset_deframer #(
		.LENGTH_BITS(LENGTH_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.marker_we(marker_we),
		.marker_byte(marker_byte),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.bytes_left(bytes_left),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.record_id(record_id),
		.dataset_id(dataset_id),
		.payload_length(payload_length),
		.payload_byte(payload_byte),
		.payload_last(payload_last),
		.done_res(done_res),
		.status(status)
	);

	always #5 clk = ~clk;

	feed_entry_t byte_feed[$];
	res_item_t due_results[$];
	int errors = 0;

	// predicted parser state
	parse_phase_t parse_phase = HUNT;
	logic [7:0] marker_now = MARKER_RESET;
	logic [7:0] rec_now = 8'd0;
	logic [7:0] set_now = 8'd0;
	logic [7:0] len_hi_byte = 8'd0;
	logic [2:0] ext_left = 3'd0;
	logic [31:0] len_acc = 32'd0;
	logic [31:0] pay_left = 32'd0;

	// stimulus generation state
	logic [7:0] gen_marker = MARKER_RESET;
	logic [31:0] gen_left = 32'd0;
	int gen_items = 0;

	// handshake bookkeeping between the clocked processes
	logic byte_accepted = 1'b0;
	logic result_accepted = 1'b0;
	int send_gap = 0;
	int send_calm = 0;
	int settle = 0;
	int recv_gap = 0;
	int recv_calm = 0;
	int hold_left = 0;
	int results_seen = 0;

	// ---------------------------------------------------------------- prediction

	task automatic queue_result(input logic [1:0] k, input logic [31:0] len,
		input logic [7:0] pb, input logic last, input logic dn, input logic [1:0] st);
		res_item_t r;
		r.kind = k;
		r.record_id = rec_now;
		r.dataset_id = set_now;
		r.payload_length = len;
		r.payload_byte = pb;
		r.payload_last = last;
		r.done_res = dn;
		r.status = st;
		due_results.insert(due_results.size(), r);
	endtask

	// length complete: check it against what is left after this byte
	task automatic close_length(input logic [31:0] rem);
		if (len_acc > rem) begin
			parse_phase = FINISHED;
			queue_result(KIND_STATUS, len_acc, 8'd0, 1'b0, 1'b1, ST_PAY_PAST);
		end else if (len_acc != 32'd0) begin
			pay_left = len_acc;
			parse_phase = IN_PAYLOAD;
			queue_result(KIND_HEADER, len_acc, 8'd0, 1'b0, 1'b0, ST_OK);
		end else if (rem < MIN_LEFT) begin
			// empty dataset right at the end of the buffer
			parse_phase = FINISHED;
			queue_result(KIND_HEADER, 32'd0, 8'd0, 1'b0, 1'b1, ST_OK);
		end else begin
			parse_phase = HUNT;
			queue_result(KIND_HEADER, 32'd0, 8'd0, 1'b0, 1'b0, ST_OK);
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b, input logic [31:0] left);
		logic [31:0] n;
		logic [31:0] rem;
		logic [15:0] word;
		logic [14:0] sos;
		logic [39:0] ext_val;
		logic last;
		logic dn;
		// a count of zero is out of range and reads as the last byte
		n = (left == 32'd0) ? 32'd1 : left;
		rem = n - 32'd1;
		case (parse_phase)
			HUNT: begin
				if (n < MIN_LEFT) begin
					// too short for any header
					parse_phase = FINISHED;
					queue_result(KIND_STATUS, 32'd0, 8'd0, 1'b0, 1'b1, ST_OK);
				end else if (b == marker_now) begin
					parse_phase = GET_RECORD;
				end else if (rem < MIN_LEFT) begin
					// skipped byte leaves too little for a header
					parse_phase = FINISHED;
					queue_result(KIND_STATUS, 32'd0, 8'd0, 1'b0, 1'b1, ST_OK);
				end
			end
			GET_RECORD: begin
				rec_now = b;
				parse_phase = GET_DATASET;
			end
			GET_DATASET: begin
				set_now = b;
				parse_phase = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				len_hi_byte = b;
				parse_phase = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				word = {len_hi_byte, b};
				if (len_hi_byte[EXT_FLAG_BIT]) begin
					// extended form: low bits give the count of length bytes
					sos = word[14:0] & SOS_MASK;
					len_acc = 32'd0;
					if (sos > SOS_MAX) begin
						parse_phase = FINISHED;
						queue_result(KIND_STATUS, 32'd0, 8'd0, 1'b0, 1'b1, ST_SOS);
					end else if (sos > rem) begin
						parse_phase = FINISHED;
						queue_result(KIND_STATUS, 32'd0, 8'd0, 1'b0, 1'b1, ST_LEN_PAST);
					end else if (sos == 15'd0) begin
						close_length(rem);
					end else begin
						ext_left = sos[2:0];
						parse_phase = GET_EXT;
					end
				end else begin
					len_acc = {16'd0, word};
					close_length(rem);
				end
			end
			GET_EXT: begin
				ext_val = {len_acc, b};
				if (ext_val > LEN_ALL_ONES)
					ext_val = LEN_ALL_ONES;
				len_acc = ext_val[31:0];
				ext_left = ext_left - 3'd1;
				if (ext_left == 3'd0)
					close_length(rem);
			end
			IN_PAYLOAD: begin
				last = (pay_left <= 32'd1);
				dn = 1'b0;
				if (last) begin
					pay_left = 32'd0;
					if (rem < MIN_LEFT) begin
						parse_phase = FINISHED;
						dn = 1'b1;
					end else begin
						parse_phase = HUNT;
					end
				end else begin
					pay_left = pay_left - 32'd1;
				end
				queue_result(KIND_PAYLOAD, len_acc, b, last, dn, ST_OK);
			end
			default: begin
				// parsing over: bytes are dropped with no result
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// ---------------------------------------------------------------- stimulus helpers

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// start count for a stretch of size bytes that cannot end parsing
	function automatic logic [31:0] pick_left(input int unsigned size);
		logic [31:0] v;
		case ($urandom_range(0, 2))
			0: v = size + 6 + $urandom_range(0, 12);
			1: v = $urandom();
			default: v = 32'hFFFF_FFFF - $urandom_range(0, 15);
		endcase
		if (v < size + 6)
			v = size + 6;
		return v;
	endfunction

	function automatic logic [7:0] pick_noise();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == gen_marker)
			b = ~b;
		return b;
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		byte_feed.insert(byte_feed.size(), feed_entry_t'{1'b0, b, gen_left});
		gen_left = gen_left - 32'd1;
		gen_items++;
	endtask

	task automatic queue_marker(input logic [7:0] v);
		byte_feed.insert(byte_feed.size(), feed_entry_t'{1'b1, v, 32'd0});
		gen_marker = v;
	endtask

	// one dataset; sos below zero picks the short length form
	task automatic queue_dataset(input logic [7:0] rec, input logic [7:0] ds,
		input logic [31:0] len, input int sos, input logic [31:0] start_left,
		input bit extremes);
		int unsigned size;
		logic [15:0] sos16;
		logic [31:0] tmp;
		int i;
		int unsigned j;
		size = 5 + ((sos > 0) ? sos : 0) + len;
		gen_left = (start_left != 32'd0) ? start_left : pick_left(size);
		queue_byte(gen_marker);
		queue_byte(rec);
		queue_byte(ds);
		if (sos < 0) begin
			queue_byte(len[15:8]);
			queue_byte(len[7:0]);
		end else begin
			sos16 = 16'(sos);
			queue_byte({1'b1, sos16[14:8]});
			queue_byte(sos16[7:0]);
			// an oversized count ends parsing at once; only a few bytes follow
			for (i = ((sos > SOS_MAX) ? SOS_MAX : sos) - 1; i >= 0; i--) begin
				tmp = len >> (8 * i);
				queue_byte(tmp[7:0]);
			end
		end
		// a length past the end is cut short; nothing after it is parsed
		for (j = 0; j < len && j < 130; j++)
			queue_byte(extremes ? ((j % 2 == 0) ? 8'h00 : 8'hFF) : 8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------- monitor
	// checks the result side, then follows marker writes and accepted items

	always @(posedge clk) begin
		res_item_t got;
		got = {kind, record_id, dataset_id, payload_length, payload_byte, payload_last,
			done_res, status};
		byte_accepted <= push && !full;
		result_accepted <= pop && !empty;
		if (arst_n) begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h", $time, got);
					errors++;
				end else begin
					res_item_t want;
					want = due_results.pop_front();
					check_field("kind", 32'(want.kind), 32'(got.kind));
					check_field("record_id", 32'(want.record_id), 32'(got.record_id));
					check_field("dataset_id", 32'(want.dataset_id), 32'(got.dataset_id));
					check_field("payload_length", want.payload_length, got.payload_length);
					check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
					check_field("payload_last", 32'(want.payload_last), 32'(got.payload_last));
					check_field("done_res", 32'(want.done_res), 32'(got.done_res));
					check_field("status", 32'(want.status), 32'(got.status));
				end
			end
			if (marker_we)
				marker_now = marker_byte;
			if (push && !full)
				deframe_byte(data_byte, bytes_left);
		end
	end

	// ---------------------------------------------------------------- driver
	// offers feed items at the falling edge; marker writes wait for a drained block

	always @(negedge clk) begin
		logic nxt_push;
		logic nxt_we;
		nxt_push = push;
		nxt_we = 1'b0;
		if (arst_n) begin
			if (push && byte_accepted) begin
				byte_feed.delete(0);
				nxt_push = 1'b0;
				// bursts with no gaps now and then
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					if ($urandom_range(0, 19) == 0)
						send_calm = $urandom_range(20, 60);
					send_gap = pick_gap();
				end
			end
			if (!nxt_push && byte_feed.size() != 0) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (byte_feed[0].is_marker_write) begin
					// the parser may still hold an item that causes no result
					if (due_results.size() == 0)
						settle++;
					else
						settle = 0;
					if (settle >= SETTLE_CYCLES) begin
						nxt_we = 1'b1;
						marker_byte <= byte_feed[0].value;
						byte_feed.delete(0);
						settle = 0;
					end
				end else begin
					nxt_push = 1'b1;
					data_byte <= byte_feed[0].value;
					bytes_left <= byte_feed[0].left;
				end
			end
		end
		push <= nxt_push;
		marker_we <= nxt_we;
	end

	// ---------------------------------------------------------------- receiver
	// random pop stalls plus two long hold-offs that back the block up to full

	always @(negedge clk) begin
		if (arst_n) begin
			if (result_accepted) begin
				results_seen++;
				if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
					hold_left = HOLD_CYCLES;
				if (recv_calm > 0) begin
					recv_calm--;
					recv_gap = 0;
				end else begin
					if ($urandom_range(0, 19) == 0)
						recv_calm = $urandom_range(20, 60);
					recv_gap = pick_gap();
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- run control

	initial begin
		ending_t ending;
		int r;
		int sos;
		int rem;
		int next_cfg_at;
		int cfg_step;
		logic [31:0] len;

		// directed: field extremes, every length form, noise at the top count
		gen_left = 32'hFFFF_FFFF;
		queue_byte(8'h00);
		queue_dataset(8'hFF, 8'h00, 32'd2, -1, 32'hFFFF_FFFE, 1'b1);
		queue_dataset(8'h00, 8'hFF, 32'd0, -1, 32'd0, 1'b0);
		queue_dataset(8'h5A, 8'hA5, 32'd0, 0, 32'd0, 1'b0);
		queue_dataset(8'h81, 8'h7E, 32'd1, 2, 32'd0, 1'b1);
		queue_marker(8'h00);

		// random: mostly well-formed datasets, some noise, marker changes
		next_cfg_at = gen_items + 90;
		cfg_step = 0;
		while (gen_items < TARGET_ITEMS) begin
			if (gen_items >= next_cfg_at && cfg_step < 4) begin
				case (cfg_step)
					0: queue_marker(8'hFF);
					2: queue_marker(MARKER_RESET);
					default: queue_marker(8'($urandom_range(0, 255)));
				endcase
				cfg_step++;
				next_cfg_at = gen_items + 90;
			end
			r = $urandom_range(0, 99);
			if (r < 15) begin
				repeat ($urandom_range(1, 4)) begin
					gen_left = pick_left(1);
					queue_byte(pick_noise());
				end
			end else begin
				r = $urandom_range(0, 99);
				if (r < 20)
					len = 0;
				else if (r < 80)
					len = $urandom_range(1, 8);
				else if (r < 95)
					len = $urandom_range(9, 40);
				else
					len = $urandom_range(60, 120);
				if ($urandom_range(0, 3) == 0)
					sos = (len == 0) ? $urandom_range(0, 4) : $urandom_range(1, 4);
				else
					sos = -1;
				queue_dataset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, sos,
					32'd0, $urandom_range(0, 9) == 0);
			end
		end

		// one way to end the buffer per run, chosen by the seed
		ending = ending_t'($urandom_range(0, 6));
		case (ending)
			END_ON_PAYLOAD: begin
				len = $urandom_range(1, 8);
				queue_dataset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, -1,
					len + 4 + $urandom_range(1, 6), 1'b0);
			end
			END_ON_EMPTY: begin
				queue_dataset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 32'd0, -1,
					$urandom_range(6, 10), 1'b0);
			end
			END_ON_SKIP: begin
				gen_left = MIN_LEFT;
				queue_byte(pick_noise());
			end
			END_SHORT: begin
				// includes a count of zero
				gen_left = $urandom_range(0, 5);
				queue_byte(8'($urandom_range(0, 255)));
			end
			END_SOS_OVER: begin
				queue_dataset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 32'd0,
					$urandom_range(SOS_MAX + 1, 32767), 32'd0, 1'b0);
			end
			END_LEN_PAST: begin
				sos = $urandom_range(2, 4);
				rem = $urandom_range(1, sos - 1);
				queue_dataset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					$urandom_range(1, 40), sos, rem + 5, 1'b0);
			end
			default: begin
				// payload past the end, with a wide length
				queue_dataset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					$urandom() | 32'h100, 4, 9 + $urandom_range(0, 200), 1'b0);
			end
		endcase
		// after the end every byte must be dropped
		repeat ($urandom_range(3, 6)) begin
			gen_left = $urandom();
			queue_byte(8'($urandom_range(0, 255)));
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (byte_feed.size() != 0 || push)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		// catch any stray result behind the last one
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("timeout: %0d items and %0d results still pending", byte_feed.size(),
			due_results.size());
		$display("testbench: FAIL");
		$finish;
	end

endmodule
